/* hw/rtl/swdk_pkg.sv */
package swdk_pkg;

	localparam int DigitCount      = 6;
	localparam int DebounceSamples = 4;
	localparam int ScanW           = 3;

	localparam logic [7:0]  TphReset = 8'd5;
	localparam logic [6:0]  HunMax   = 7'd99;
	localparam logic [13:0] SecMax   = 14'd9999;
	localparam logic [3:0]  DigitMax = 4'd9;

	localparam logic [7:0] SegBlank = 8'hFF;
	localparam logic [7:0] DpMask   = 8'h7F;

	// BCD view of the time, digit 0 is the least significant
	typedef struct packed {
		logic [1:0][3:0] hun_bcd;
		logic [3:0][3:0] sec_bcd;
	} disp_time_t;

	typedef struct packed {
		logic rel_reset;
		logic rel_start;
	} key_evt_t;

	// active-low common-anode pattern, decimal point off
	function automatic logic [7:0] seg_of(input logic [3:0] d);
		logic [7:0] s;
		case (d)
			4'd0: s = 8'hC0;
			4'd1: s = 8'hF9;
			4'd2: s = 8'hA4;
			4'd3: s = 8'hB0;
			4'd4: s = 8'h99;
			4'd5: s = 8'h92;
			4'd6: s = 8'h82;
			4'd7: s = 8'hF8;
			4'd8: s = 8'h80;
			4'd9: s = 8'h90;
			default: s = SegBlank;
		endcase
		return s;
	endfunction

endpackage

/* hw/rtl/swdk_in_if.sv */
interface swdk_in_if;
	logic valid;
	logic ready;
	logic reset_key_level;
	logic start_key_level;

	modport source (output valid, output reset_key_level, output start_key_level, input ready);
	modport sink (input valid, input reset_key_level, input start_key_level, output ready);
endinterface

/* hw/rtl/swdk_out_if.sv */
interface swdk_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  scan_digit;
	logic [7:0]  segments;
	logic [13:0] seconds;
	logic [6:0]  hundredths;
	logic        running;

	modport source (output valid, output scan_digit, output segments, output seconds,
		output hundredths, output running, input ready);
	modport sink (input valid, input scan_digit, input segments, input seconds,
		input hundredths, input running, output ready);
endinterface

/* hw/rtl/swdk_debounce.sv */
module swdk_debounce (
	input  logic clk,
	input  logic arst_n,
	input  logic fire,
	input  logic level,
	output logic released
);

	localparam int N = swdk_pkg::DebounceSamples;

	logic [N-1:0] hist_q;
	logic         stable_q;
	logic [N-1:0] hist_n;

	assign hist_n   = {hist_q[N-2:0], level};
	assign released = fire && (&hist_n) && !stable_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q   <= '1;
			stable_q <= 1'b1;
		end else if (fire) begin
			hist_q <= hist_n;
			if (&hist_n) begin
				stable_q <= 1'b1;
			end else if (hist_n == '0) begin
				stable_q <= 1'b0;
			end
		end
	end

endmodule

/* hw/rtl/swdk_counter.sv */
module swdk_counter (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  fire,
	input  logic [7:0]            tph,
	input  swdk_pkg::key_evt_t    evt,
	output swdk_pkg::disp_time_t  adv_time,
	output logic [13:0]           sec_next,
	output logic [6:0]            hun_next,
	output logic                  run_next
);

	logic [7:0]            sub_q;
	logic [6:0]            hun_q;
	logic [13:0]           sec_q;
	logic                  run_q;
	swdk_pkg::disp_time_t  time_q;

	logic [7:0]            tph_eff;
	logic [8:0]            s_sum;
	logic                  hit;
	logic [7:0]            sub_n;
	logic                  sec_carry;
	logic [6:0]            hun_adv;
	logic [13:0]           sec_adv;
	logic                  c;

	assign tph_eff = (tph == 8'd0) ? 8'd1 : tph;
	assign s_sum   = {1'b0, sub_q} + 9'd1;
	assign hit     = run_q && (s_sum >= {1'b0, tph_eff});

	always_comb begin
		sub_n = sub_q;
		if (run_q) begin
			sub_n = hit ? 8'(s_sum - {1'b0, tph_eff}) : s_sum[7:0];
		end
	end

	// advance hundredths, carry into seconds; binary and BCD move together
	always_comb begin
		adv_time  = time_q;
		hun_adv   = hun_q;
		sec_adv   = sec_q;
		sec_carry = 1'b0;
		c         = 1'b0;
		if (hit) begin
			if (hun_q == swdk_pkg::HunMax) begin
				hun_adv           = '0;
				adv_time.hun_bcd  = '0;
				sec_carry         = 1'b1;
			end else begin
				hun_adv = hun_q + 7'd1;
				if (time_q.hun_bcd[0] == swdk_pkg::DigitMax) begin
					adv_time.hun_bcd[0] = 4'd0;
					adv_time.hun_bcd[1] = time_q.hun_bcd[1] + 4'd1;
				end else begin
					adv_time.hun_bcd[0] = time_q.hun_bcd[0] + 4'd1;
				end
			end
		end
		if (sec_carry) begin
			sec_adv = (sec_q == swdk_pkg::SecMax) ? '0 : sec_q + 14'd1;
		end
		c = sec_carry;
		for (int i = 0; i < 4; i++) begin
			if (c) begin
				if (time_q.sec_bcd[i] == swdk_pkg::DigitMax) begin
					adv_time.sec_bcd[i] = 4'd0;
				end else begin
					adv_time.sec_bcd[i] = time_q.sec_bcd[i] + 4'd1;
					c = 1'b0;
				end
			end
		end
	end

	// reset release first, then start release toggles
	assign hun_next = evt.rel_reset ? '0 : hun_adv;
	assign sec_next = evt.rel_reset ? '0 : sec_adv;
	assign run_next = (evt.rel_reset ? 1'b0 : run_q) ^ evt.rel_start;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sub_q  <= '0;
			hun_q  <= '0;
			sec_q  <= '0;
			run_q  <= 1'b0;
			time_q <= '0;
		end else if (fire) begin
			sub_q  <= sub_n;
			hun_q  <= hun_next;
			sec_q  <= sec_next;
			run_q  <= run_next;
			time_q <= evt.rel_reset ? '0 : adv_time;
		end
	end

endmodule

/* hw/rtl/swdk_seg_decode.sv */
module swdk_seg_decode (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 fire,
	input  swdk_pkg::disp_time_t t,
	output logic [2:0]           pos,
	output logic [7:0]           seg
);

	localparam int W = swdk_pkg::ScanW;

	logic [W-1:0] scan_q;
	logic [W:0]   pos_inc;
	logic [W-1:0] scan_n;

	assign pos     = (32'(scan_q) >= swdk_pkg::DigitCount) ? '0 : scan_q;
	assign pos_inc = {1'b0, pos} + (W+1)'(1);
	assign scan_n  = (32'(pos_inc) >= swdk_pkg::DigitCount) ? '0 : pos_inc[W-1:0];

	// upper seconds digits blank while they and all digits above are zero
	always_comb begin
		case (pos)
			3'd0: seg = swdk_pkg::seg_of(t.hun_bcd[0]);
			3'd1: seg = swdk_pkg::seg_of(t.hun_bcd[1]);
			3'd2: seg = swdk_pkg::seg_of(t.sec_bcd[0]) & swdk_pkg::DpMask;
			3'd3: seg = (t.sec_bcd[3:1] == '0) ? swdk_pkg::SegBlank
				: swdk_pkg::seg_of(t.sec_bcd[1]);
			3'd4: seg = (t.sec_bcd[3:2] == '0) ? swdk_pkg::SegBlank
				: swdk_pkg::seg_of(t.sec_bcd[2]);
			3'd5: seg = (t.sec_bcd[3] == 4'd0) ? swdk_pkg::SegBlank
				: swdk_pkg::seg_of(t.sec_bcd[3]);
			default: seg = swdk_pkg::SegBlank;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q <= '0;
		end else if (fire) begin
			scan_q <= scan_n;
		end
	end

endmodule

/* hw/rtl/stopwatch_with_debounced_keys_top.sv */
// A result is offered in the cycle after its tick transfers.
// Throughput: one tick per cycle while disp_out.ready is high; the output register
// lets a new tick transfer in the same cycle the previous result is taken.
// Reset (arst_n low): time, run flag and scan position clear, keys read released,
// ticks_per_hundredth returns to 5, no result pending.
module stopwatch_with_debounced_keys_top (
	input  logic        clk,
	input  logic        arst_n,
	swdk_in_if.sink     key_in,
	swdk_out_if.source  disp_out,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata
);

	logic                  tph_q;
	logic [7:0]            tph_val_q;
	logic                  in_fire;
	swdk_pkg::key_evt_t    evt;
	swdk_pkg::disp_time_t  adv_time;
	logic [13:0]           sec_next;
	logic [6:0]            hun_next;
	logic                  run_next;
	logic [2:0]            pos;
	logic [7:0]            seg;

	logic                  out_valid_q;
	logic [2:0]            scan_digit_q;
	logic [7:0]            segments_q;
	logic [13:0]           seconds_q;
	logic [6:0]            hundredths_q;
	logic                  running_q;

	assign key_in.ready = !out_valid_q || disp_out.ready;
	assign in_fire      = key_in.valid && key_in.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tph_val_q <= swdk_pkg::TphReset;
			tph_q     <= 1'b0;
		end else if (cfg_we) begin
			tph_val_q <= cfg_wdata;
			tph_q     <= 1'b1;
		end
	end

	swdk_debounce u_reset_key (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (in_fire),
		.level    (key_in.reset_key_level),
		.released (evt.rel_reset)
	);

	swdk_debounce u_start_key (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (in_fire),
		.level    (key_in.start_key_level),
		.released (evt.rel_start)
	);

	swdk_counter u_counter (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (in_fire),
		.tph      (tph_val_q),
		.evt      (evt),
		.adv_time (adv_time),
		.sec_next (sec_next),
		.hun_next (hun_next),
		.run_next (run_next)
	);

	swdk_seg_decode u_decode (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (in_fire),
		.t      (adv_time),
		.pos    (pos),
		.seg    (seg)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_fire) begin
			out_valid_q <= 1'b1;
		end else if (disp_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload, loaded on each tick transfer
	always_ff @(posedge clk) begin
		if (in_fire) begin
			scan_digit_q <= pos;
			segments_q   <= seg;
			seconds_q    <= sec_next;
			hundredths_q <= hun_next;
			running_q    <= run_next;
		end
	end

	assign disp_out.valid      = out_valid_q;
	assign disp_out.scan_digit = scan_digit_q;
	assign disp_out.segments   = segments_q;
	assign disp_out.seconds    = seconds_q;
	assign disp_out.hundredths = hundredths_q;
	assign disp_out.running    = running_q;

	a_in_fire_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> out_valid_q)
		else $error("accepted tick produced no result");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !disp_out.ready) |-> !key_in.ready)
		else $error("tick accepted while result stalled");

	a_time_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (hundredths_q <= swdk_pkg::HunMax && seconds_q <= swdk_pkg::SecMax))
		else $error("time out of range");

	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (32'(scan_digit_q) < swdk_pkg::DigitCount))
		else $error("scan position out of range");

	a_cfg_seen: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> (tph_q && tph_val_q == $past(cfg_wdata)))
		else $error("configuration write lost");

endmodule
